FILE: hw/rtl/wwgs_pkg.sv
// Shared types, codes and defaults for the Wireworld generation step block.
`default_nettype none

package wwgs_pkg;

	// Default grid bounds
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Field widths fixed by the interface
	localparam int COORD_W = 6;
	localparam int DIM_W   = 7;

	typedef logic [1:0]         cell_t;
	typedef logic [1:0]         mode_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [DIM_W-1:0]   cfg_data_t;
	typedef logic               reg_idx_t;

	// Cell codes
	localparam cell_t CELL_EMPTY = 2'd0;
	localparam cell_t CELL_HEAD  = 2'd1;
	localparam cell_t CELL_TAIL  = 2'd2;
	localparam cell_t CELL_WIRE  = 2'd3;

	// Item modes
	localparam mode_t MODE_WRITE = 2'd0;
	localparam mode_t MODE_STEP  = 2'd1;
	localparam mode_t MODE_READ  = 2'd2;

	// Register indexes
	localparam reg_idx_t REG_GRID_WIDTH  = 1'b0;
	localparam reg_idx_t REG_GRID_HEIGHT = 1'b1;

	localparam dim_t DIM_RESET = 7'd64;

	typedef struct packed {
		mode_t  mode;
		coord_t cell_x;
		coord_t cell_y;
		cell_t  cell_value;
	} req_word_t;

	typedef struct packed {
		cell_t cell_state;
		logic  step_done;
	} rsp_word_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic clear;
		logic start_step;
		logic sweep;
		logic flip;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic step_req;
		logic clear_end;
		logic sweep_end;
	} status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wwgs_req_if.sv
// Request channel: valid/ready handshake carrying one item word.
`default_nettype none

interface wwgs_req_if;
	logic                 valid;
	logic                 ready;
	wwgs_pkg::req_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wwgs_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
`default_nettype none

interface wwgs_rsp_if;
	logic                 valid;
	logic                 ready;
	wwgs_pkg::rsp_word_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/wwgs_ctrl.sv
// Controller state machine: clearing pass, item acceptance, sweep and result hand-off.
`default_nettype none

module wwgs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	input  wire wwgs_pkg::status_t status,
	output wwgs_pkg::cmd_t       cmd
);
	import wwgs_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_STEP   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign req_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (status.step_req) begin
						cmd.start_step = 1'b1;
						state_d        = S_STEP;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_STEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last cell of the sweep is written this cycle
				cmd.flip = 1'b1;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/wwgs_dp.sv
// Datapath: grid banks, line buffer, 3x3 window, sweep counters and result register.
`default_nettype none

module wwgs_dp #(
	parameter int MAX_WIDTH  = wwgs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wwgs_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire wwgs_pkg::reg_idx_t   cfg_index,
	input  wire wwgs_pkg::cfg_data_t  cfg_data,
	input  wire wwgs_pkg::req_word_t  req_data,
	input  wire wwgs_pkg::cmd_t       cmd,
	output wwgs_pkg::status_t         status,
	output wwgs_pkg::rsp_word_t       rsp_data
);
	import wwgs_pkg::*;

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int XIW   = $clog2(MAX_WIDTH);

	// One column of the 3x3 window: head flags above and below, code in the middle
	typedef struct packed {
		logic  top;
		cell_t mid;
		logic  bot;
	} col_t;

	// Line buffer entry: head flag two rows up, code one row up
	typedef struct packed {
		logic  top;
		cell_t mid;
	} lb_t;

	dim_t grid_width_q, grid_height_q;
	logic cur_bank_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_RESET;
			grid_height_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Item decode
	logic          in_grid;
	logic [AW-1:0] cell_addr;
	logic          wr_item, item_re;

	assign in_grid = (32'(req_data.cell_x) < 32'(grid_width_q))
		&& (32'(req_data.cell_x) < 32'(MAX_WIDTH))
		&& (32'(req_data.cell_y) < 32'(grid_height_q))
		&& (32'(req_data.cell_y) < 32'(MAX_HEIGHT));
	assign cell_addr = AW'(AW'(req_data.cell_y) * AW'(MAX_WIDTH)) + AW'(req_data.cell_x);
	assign wr_item   = cmd.accept && (req_data.mode == MODE_WRITE) && in_grid;
	assign item_re   = cmd.accept && (req_data.mode == MODE_READ) && in_grid;

	// Sweep position (one column and one row past the grid to flush the window)
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [AW-1:0] rdaddr_q, wraddr_q;
	logic          x_live, y_live, src_re, lb_re;
	logic          gen_we;

	assign x_live = (x_q != XW'(MAX_WIDTH));
	assign y_live = (y_q != YW'(MAX_HEIGHT));
	assign src_re = cmd.sweep && x_live && y_live;
	assign lb_re  = cmd.sweep && x_live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			rdaddr_q <= '0;
			wraddr_q <= '0;
		end else begin
			if (cmd.start_step) begin
				x_q      <= '0;
				y_q      <= '0;
				rdaddr_q <= '0;
				wraddr_q <= '0;
			end else begin
				if (cmd.sweep) begin
					if (!x_live) begin
						x_q <= '0;
						y_q <= y_q + 1'b1;
					end else begin
						x_q <= x_q + 1'b1;
					end
				end
				if (src_re) begin
					rdaddr_q <= rdaddr_q + 1'b1;
				end
				if (cmd.clear || gen_we) begin
					wraddr_q <= wraddr_q + 1'b1;
				end
			end
		end
	end

	assign status.step_req  = (req_data.mode == MODE_STEP);
	assign status.clear_end = (wraddr_q == AW'(CELLS - 1));
	assign status.sweep_end = !x_live && !y_live;

	// Stage 1 position
	logic          valid_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.sweep;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_q;
		y_s1 <= y_q;
	end

	// Grid banks: clear writes both, item writes the current bank, sweep the other
	cell_t         bank_a_q [CELLS];
	cell_t         bank_b_q [CELLS];
	cell_t         rd_a_q, rd_b_q;
	logic          we_a, we_b, re_a, re_b;
	logic [AW-1:0] waddr, raddr;
	cell_t         wdata, next_code;

	assign we_a  = cmd.clear || (wr_item && !cur_bank_q) || (gen_we && cur_bank_q);
	assign we_b  = cmd.clear || (wr_item && cur_bank_q) || (gen_we && !cur_bank_q);
	assign re_a  = (item_re || src_re) && !cur_bank_q;
	assign re_b  = (item_re || src_re) && cur_bank_q;
	assign waddr = wr_item ? cell_addr : wraddr_q;
	assign raddr = item_re ? cell_addr : rdaddr_q;
	assign wdata = cmd.clear ? CELL_EMPTY : (wr_item ? req_data.cell_value : next_code);

	always_ff @(posedge clk) begin
		if (we_a) begin
			bank_a_q[waddr] <= wdata;
		end
		if (re_a) begin
			rd_a_q <= bank_a_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_b) begin
			bank_b_q[waddr] <= wdata;
		end
		if (re_b) begin
			rd_b_q <= bank_b_q[raddr];
		end
	end

	// Line buffer holding the two rows above the incoming one
	lb_t  lb_q [MAX_WIDTH];
	lb_t  lb_rd_q;
	lb_t  lb_wdata;
	logic x_live_s1, y_live_s1, in_used;
	cell_t src_code, bot_code;
	col_t ncol, wl_q, wc_q;

	assign src_code  = cur_bank_q ? rd_b_q : rd_a_q;
	assign x_live_s1 = (x_s1 != XW'(MAX_WIDTH));
	assign y_live_s1 = (y_s1 != YW'(MAX_HEIGHT));
	assign in_used   = x_live_s1 && y_live_s1
		&& (32'(x_s1) < 32'(grid_width_q)) && (32'(y_s1) < 32'(grid_height_q));
	assign bot_code  = in_used ? src_code : CELL_EMPTY;

	assign ncol.top = x_live_s1 && (32'(y_s1) >= 32'd2) && lb_rd_q.top;
	assign ncol.mid = (x_live_s1 && (y_s1 != '0)) ? lb_rd_q.mid : CELL_EMPTY;
	assign ncol.bot = (bot_code == CELL_HEAD);

	assign lb_wdata.top = (ncol.mid == CELL_HEAD);
	assign lb_wdata.mid = bot_code;

	always_ff @(posedge clk) begin
		if (valid_s1 && x_live_s1) begin
			lb_q[x_s1[XIW-1:0]] <= lb_wdata;
		end
		if (lb_re) begin
			lb_rd_q <= lb_q[x_q[XIW-1:0]];
		end
	end

	// Window shift; a new row starts with an empty left column
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (x_s1 == '0) begin
				wl_q <= '0;
			end else begin
				wl_q <= wc_q;
			end
			wc_q <= ncol;
		end
	end

	// Rule for the centre cell of the window
	logic [3:0] heads;

	assign gen_we = valid_s1 && (x_s1 != '0) && (y_s1 != '0);
	assign heads  = 4'(wl_q.top) + 4'(wl_q.mid == CELL_HEAD) + 4'(wl_q.bot)
		+ 4'(wc_q.top) + 4'(wc_q.bot)
		+ 4'(ncol.top) + 4'(ncol.mid == CELL_HEAD) + 4'(ncol.bot);

	always_comb begin
		case (wc_q.mid)
			CELL_HEAD: next_code = CELL_TAIL;
			CELL_TAIL: next_code = CELL_WIRE;
			CELL_WIRE: next_code = ((heads == 4'd1) || (heads == 4'd2)) ? CELL_HEAD : CELL_WIRE;
			default:   next_code = CELL_EMPTY;
		endcase
	end

	// Bank select and result register
	mode_t     mode_q;
	logic      in_grid_q;
	rsp_word_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_bank_q <= 1'b0;
		end else if (cmd.flip) begin
			cur_bank_q <= !cur_bank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q    <= req_data.mode;
			in_grid_q <= in_grid;
		end
		if (cmd.load_out) begin
			rsp_q.cell_state <= ((mode_q == MODE_READ) && in_grid_q) ? src_code : CELL_EMPTY;
			rsp_q.step_done  <= (mode_q == MODE_STEP);
		end
	end

	assign rsp_data = rsp_q;

endmodule

`default_nettype wire

FILE: hw/rtl/wireworld_generation_step_top.sv
// Top level of the Wireworld generation step block.
`default_nettype none

// Wireworld grid engine with two ping-pong banks of MAX_WIDTH x MAX_HEIGHT two-bit
// cells. After reset a clearing pass empties both banks; no word is taken during
// it, configuration writes are. A write or read word goes from acceptance through
// the finish state into the output register. A step word sweeps the current bank
// one cell per cycle through a single bank read port, a line buffer and a 3x3
// window, over one extra column and row to flush the window. One word is in work
// at a time; a finished result waits in the output register, the next word can be
// taken while it waits, and its result is loaded once the output register is free.
module wireworld_generation_step_top #(
	parameter int MAX_WIDTH  = wwgs_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wwgs_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire wwgs_pkg::reg_idx_t   cfg_index,
	input  wire wwgs_pkg::cfg_data_t  cfg_data,
	wwgs_req_if.sink                  req,
	wwgs_rsp_if.source                rsp
);
	import wwgs_pkg::*;

	cmd_t    cmd;
	status_t status;

	wwgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	wwgs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req.data),
		.cmd       (cmd),
		.status    (status),
		.rsp_data  (rsp.data)
	);

endmodule

`default_nettype wire

FILE: tb/wwgs_checker.sv
// Checker for the Wireworld generation step block: grid predictor and result comparison.
`default_nettype none

module wwgs_checker
	import wwgs_pkg::*;
#(
	parameter int GRID_COLS = DEF_MAX_WIDTH,
	parameter int GRID_ROWS = DEF_MAX_HEIGHT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire reg_idx_t   cfg_index,
	input  wire cfg_data_t  cfg_data,
	wwgs_req_if             req,
	wwgs_rsp_if             rsp,
	output int              mismatches,
	output int              outstanding
);

	localparam int CELLS = GRID_COLS * GRID_ROWS;

	// Model of the current grid and the bounds in use
	cell_t     live_grid [CELLS];
	dim_t      grid_w;
	dim_t      grid_h;
	rsp_word_t rsp_due_q [$];
	rsp_word_t due_word;
	rsp_word_t seen_word;
	int        bad_fields;
	int        due_count;

	assign mismatches  = bad_fields;
	assign outstanding = due_count;

	// Oversized bounds clamp to the store size
	function automatic int span(dim_t d, int lim);
		return (int'(d) > lim) ? lim : int'(d);
	endfunction

	// One generation over the whole store; cells outside the grid in use end up empty
	function automatic void advance_generation();
		cell_t next_grid [CELLS];
		int    w;
		int    h;
		int    heads;
		int    nx;
		int    ny;
		w = span(grid_w, GRID_COLS);
		h = span(grid_h, GRID_ROWS);
		for (int y = 0; y < GRID_ROWS; y++) begin
			for (int x = 0; x < GRID_COLS; x++) begin
				next_grid[y*GRID_COLS + x] = CELL_EMPTY;
				if (x < w && y < h) begin
					case (live_grid[y*GRID_COLS + x])
						CELL_HEAD: next_grid[y*GRID_COLS + x] = CELL_TAIL;
						CELL_TAIL: next_grid[y*GRID_COLS + x] = CELL_WIRE;
						CELL_WIRE: begin
							heads = 0;
							for (int dy = -1; dy <= 1; dy++) begin
								for (int dx = -1; dx <= 1; dx++) begin
									nx = x + dx;
									ny = y + dy;
									if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h
											&& live_grid[ny*GRID_COLS + nx] == CELL_HEAD)
										heads++;
								end
							end
							next_grid[y*GRID_COLS + x] = (heads == 1 || heads == 2) ? CELL_HEAD : CELL_WIRE;
						end
						default: ;
					endcase
				end
			end
		end
		live_grid = next_grid;
	endfunction

	// Apply one request word to the grid and give the result word it should produce
	function automatic rsp_word_t apply_word(req_word_t w);
		rsp_word_t r;
		logic      in_use;
		int        idx;
		r      = '0;
		in_use = int'(w.cell_x) < span(grid_w, GRID_COLS) && int'(w.cell_y) < span(grid_h, GRID_ROWS);
		idx    = int'(w.cell_y) * GRID_COLS + int'(w.cell_x);
		case (w.mode)
			MODE_WRITE: if (in_use) live_grid[idx] = w.cell_value;
			MODE_STEP: begin
				advance_generation();
				r.step_done = 1'b1;
			end
			MODE_READ: if (in_use) r.cell_state = live_grid[idx];
			default: ;
		endcase
		return r;
	endfunction

	// Watch configuration, requests and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (live_grid[i]) live_grid[i] = CELL_EMPTY;
			grid_w     = DIM_RESET;
			grid_h     = DIM_RESET;
			rsp_due_q.delete();
			bad_fields = 0;
			due_count  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_WIDTH:  grid_w = cfg_data;
					REG_GRID_HEIGHT: grid_h = cfg_data;
					default: ;
				endcase
			end
			// result words against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				seen_word = rsp.data;
				if (rsp_due_q.size() == 0) begin
					$error("unexpected result word: cell_state %0d step_done %0d",
						seen_word.cell_state, seen_word.step_done);
					bad_fields++;
				end else begin
					due_word = rsp_due_q.pop_front();
					if (seen_word.cell_state !== due_word.cell_state) begin
						$error("cell_state: expected %0d, got %0d",
							due_word.cell_state, seen_word.cell_state);
						bad_fields++;
					end
					if (seen_word.step_done !== due_word.step_done) begin
						$error("step_done: expected %0d, got %0d",
							due_word.step_done, seen_word.step_done);
						bad_fields++;
					end
				end
			end
			if (req.valid && req.ready)
				rsp_due_q.push_back(apply_word(req.data));
			due_count = rsp_due_q.size();
		end
	end

endmodule

`default_nettype wire

FILE: tb/wireworld_generation_step_top_test.sv
// Testbench top for the Wireworld generation step block: clock, reset, stimulus and verdict.
`default_nettype none

module wireworld_generation_step_top_test;
	import wwgs_pkg::*;

	localparam int    GRID_MAX_W   = DEF_MAX_WIDTH;
	localparam int    GRID_MAX_H   = DEF_MAX_HEIGHT;
	localparam int    CYCLE_LIMIT  = 3000000;
	localparam int    RANDOM_ITEMS = 115;
	localparam mode_t MODE_UNUSED  = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	reg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	int        mismatches;
	int        outstanding;

	// Sender state and the bounds the grid is using
	int burst_left;
	int uw;
	int uh;

	wwgs_req_if req_ch ();
	wwgs_rsp_if rsp_ch ();

	wireworld_generation_step_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	wwgs_checker #(
		.GRID_COLS (GRID_MAX_W),
		.GRID_ROWS (GRID_MAX_H)
	) grid_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock
	initial begin : clock_gen
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up on a hung run
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wireworld_generation_step_top test failed");
		$finish;
	end

	// Result side: stall style changes every so often, including spells with no stalls
	initial begin : rsp_stall
		int style;
		int style_left;
		int hold;
		rsp_ch.ready = 1'b0;
		style        = 0;
		style_left   = 0;
		hold         = 0;
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				style      = $urandom_range(0, 2);
				style_left = $urandom_range(50, 300);
			end
			style_left--;
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (style == 1 && $urandom_range(0, 1) == 1)
					hold = $urandom_range(1, 3);
				else if (style == 2 && $urandom_range(0, 15) == 0)
					hold = $urandom_range(5, 20);
			end
		end
	end

	// Offer one request word, in bursts with random gaps
	task automatic send_item(mode_t m, coord_t x, coord_t y, cell_t v);
		int        gap;
		req_word_t w;
		w.mode       = m;
		w.cell_x     = x;
		w.cell_y     = y;
		w.cell_value = v;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
	endtask

	// Stop offering words and wait for every result to come back
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Reprogram the grid bounds while the block is idle
	task automatic set_dims(dim_t w, dim_t h);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data  <= w;
		@(negedge clk);
		cfg_index <= REG_GRID_HEIGHT;
		cfg_data  <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		uw = (int'(w) > GRID_MAX_W) ? GRID_MAX_W : int'(w);
		uh = (int'(h) > GRID_MAX_H) ? GRID_MAX_H : int'(h);
	endtask

	function automatic coord_t rand_col();
		return coord_t'($urandom_range(0, uw - 1));
	endfunction

	function automatic coord_t rand_row();
		return coord_t'($urandom_range(0, uh - 1));
	endfunction

	// Conductor half the time so that signals have somewhere to travel
	function automatic cell_t rand_code();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return CELL_WIRE;
		else if (r < 7)
			return CELL_HEAD;
		else if (r < 8)
			return CELL_TAIL;
		return CELL_EMPTY;
	endfunction

	// Stimulus
	initial begin : stimulus
		int    items_sent;
		int    pick;
		int    r;
		dim_t  new_w;
		dim_t  new_h;
		mode_t m;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_GRID_WIDTH;
		cfg_data     = '0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		burst_left   = 0;
		items_sent   = 0;
		uw           = GRID_MAX_W;
		uh           = GRID_MAX_H;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Full grid: heads next to conductors with one, two and three head neighbours
		send_item(MODE_WRITE, 0, 0, CELL_HEAD);
		send_item(MODE_WRITE, 0, 1, CELL_HEAD);
		send_item(MODE_WRITE, 0, 2, CELL_HEAD);
		send_item(MODE_WRITE, 1, 0, CELL_WIRE);
		send_item(MODE_WRITE, 1, 1, CELL_WIRE);
		send_item(MODE_WRITE, 1, 3, CELL_WIRE);
		send_item(MODE_WRITE, 62, 62, CELL_HEAD);
		send_item(MODE_WRITE, 63, 63, CELL_WIRE);
		send_item(MODE_WRITE, 63, 0, CELL_TAIL);
		send_item(MODE_UNUSED, 63, 63, CELL_WIRE);
		send_item(MODE_STEP, 0, 0, CELL_EMPTY);
		send_item(MODE_READ, 1, 0, CELL_EMPTY);
		send_item(MODE_READ, 1, 1, CELL_EMPTY);
		send_item(MODE_READ, 1, 3, CELL_EMPTY);
		send_item(MODE_READ, 0, 0, CELL_EMPTY);
		send_item(MODE_READ, 63, 63, CELL_EMPTY);
		send_item(MODE_READ, 63, 0, CELL_EMPTY);

		// No column in use: writes dropped, reads give empty, the step still completes
		set_dims(7'd0, 7'd127);
		send_item(MODE_WRITE, 0, 0, CELL_HEAD);
		send_item(MODE_READ, 0, 0, CELL_EMPTY);
		send_item(MODE_STEP, 0, 0, CELL_EMPTY);

		// Oversized bounds act as the full store
		set_dims(7'd127, 7'd100);
		send_item(MODE_WRITE, 40, 40, CELL_WIRE);
		send_item(MODE_READ, 40, 40, CELL_EMPTY);

		// Outside the grid: write dropped, read empty, and a step empties the rest of the store
		set_dims(7'd4, 7'd3);
		send_item(MODE_WRITE, 10, 1, CELL_HEAD);
		send_item(MODE_READ, 10, 1, CELL_EMPTY);
		send_item(MODE_STEP, 0, 0, CELL_EMPTY);
		set_dims(7'd64, 7'd64);
		send_item(MODE_READ, 40, 40, CELL_EMPTY);

		// Random phases: new bounds, seed a pattern, step it, then mixed traffic
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				new_w = $urandom_range(0, 1) ? 7'd0 : dim_t'($urandom_range(1, 8));
				new_h = (new_w == 7'd0) ? dim_t'($urandom_range(0, 127)) : 7'd0;
			end else if (pick == 1) begin
				new_w = dim_t'($urandom_range(65, 127));
				new_h = 7'd64;
			end else if (pick == 2) begin
				new_w = 7'd1;
				new_h = dim_t'($urandom_range(1, 64));
			end else begin
				new_w = dim_t'($urandom_range(1, 8));
				new_h = dim_t'($urandom_range(1, 8));
			end
			set_dims(new_w, new_h);

			if (uw > 0 && uh > 0) begin
				repeat ($urandom_range(3, 10)) begin
					send_item(MODE_WRITE, rand_col(), rand_row(), rand_code());
					items_sent++;
				end
			end
			send_item(MODE_STEP, coord_t'($urandom), coord_t'($urandom), cell_t'($urandom));
			items_sent++;

			repeat ($urandom_range(6, 14)) begin
				r = $urandom_range(0, 19);
				if (r < 2) begin
					send_item(MODE_STEP, coord_t'($urandom), coord_t'($urandom), cell_t'($urandom));
					items_sent++;
				end else if (r < 10 && uw > 0 && uh > 0) begin
					send_item(MODE_READ, rand_col(), rand_row(), cell_t'($urandom));
					items_sent++;
				end else if (r < 16 && uw > 0 && uh > 0) begin
					send_item(MODE_WRITE, rand_col(), rand_row(), rand_code());
					items_sent++;
				end else begin
					// noise anywhere in the coordinate space, unused mode included
					pick = $urandom_range(0, 2);
					m    = (pick == 0) ? MODE_WRITE : (pick == 1) ? MODE_READ : MODE_UNUSED;
					send_item(m, coord_t'($urandom), coord_t'($urandom), cell_t'($urandom));
					items_sent++;
				end
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("wireworld_generation_step_top test passed");
		else
			$display("wireworld_generation_step_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
